### sv/gbts_pkg.sv
// gbts_pkg: request codes, status codes and the front/back queue entry type
// for the gap buffer text store. No dependencies.
`timescale 1ns / 1ps
package gbts_pkg;
    typedef enum logic [2:0] {
        FN_SET  = 3'd0,
        FN_INSA = 3'd1,
        FN_INS  = 3'd2,
        FN_DEL  = 3'd3,
        FN_READ = 3'd4,
        FN_NEXT = 3'd5,
        FN_PREV = 3'd6,
        FN_REPL = 3'd7
    } func_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_OOR  = 2'd2;

    typedef struct packed {
        func_t       func;
        logic [7:0]  char_in;
        logic [10:0] position;
        logic [10:0] count;
    } req_t;
endpackage

### sv/gap_buffer_text_store.sv
// Gap buffer text store, top level: request queue front end and executor.
// Set cursor completes as taken; read/next/previous read in S_EXEC, load in
// S_DATA; a gap move does one read (S_EXEC) and one write (S_WR) per byte.
// Throughput: one request at a time in the executor; the queue takes up to
// two requests ahead. Reset: asynchronous active-low rst_n empties the queue,
// clears the gap to the whole store and the cursor to zero; store bytes stay.
`timescale 1ns / 1ps
module gap_buffer_text_store #(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: func[2:0], char_in[10:3], position[21:11], count[32:22], zero pad
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: char_out[7:0], text_length[18:8], cursor_pos[29:19],
    // free_space[40:30], status[42:41], zero pad
    output logic [47:0] m_tdata
);
    import gbts_pkg::*;

    req_t in_req, q_req;
    logic q_valid, q_take;
    logic [7:0]  char_out;
    logic [10:0] text_length, cursor_pos, free_space;
    logic [1:0]  status;

    // unpack request fields
    assign in_req.func     = func_t'(s_tdata[2:0]);
    assign in_req.char_in  = s_tdata[10:3];
    assign in_req.position = s_tdata[21:11];
    assign in_req.count    = s_tdata[32:22];

    gbts_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
        .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
    );

    gbts_back #(.CAPACITY(CAPACITY)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_take(q_take), .q_req(q_req),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .char_out(char_out), .text_length(text_length),
        .cursor_pos(cursor_pos), .free_space(free_space), .status(status)
    );

    assign m_tdata = {5'd0, status, free_space, cursor_pos, text_length, char_out};
endmodule

### sv/gbts_front.sv
// gbts_front: input side, a two-entry request queue toward the executor.
// Depends on gbts_pkg.
`timescale 1ns / 1ps
module gbts_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  gbts_pkg::req_t    in_req,
    output logic              q_valid,
    input  logic              q_take,
    output gbts_pkg::req_t    q_req
);
    import gbts_pkg::*;

    req_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_take;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push)
        else $error("push into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_take |=> q_valid && $stable(q_req))
        else $error("queue head changed while waiting");
endmodule

### sv/gbts_back.sv
// gbts_back: runs requests on the gap buffer memory, one byte copied per S_EXEC
// and S_WR pass in gap moves; holds the result register. Depends on gbts_pkg.
`timescale 1ns / 1ps
module gbts_back #(
    parameter int CAPACITY = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_take,
    input  gbts_pkg::req_t    q_req,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [7:0]        char_out,
    output logic [10:0]       text_length,
    output logic [10:0]       cursor_pos,
    output logic [10:0]       free_space,
    output logic [1:0]        status
);
    import gbts_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    // wide enough for the full capacity and for the 11-bit request fields
    localparam int PW = (AW + 1 > 11) ? AW + 1 : 11;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WR   = 4'b0010,
        S_EXEC = 4'b0100,
        S_DATA = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    req_t          req_reg;
    logic [PW-1:0] gf_reg, gp_reg, cur_reg;
    logic [PW-1:0] gf_next, gp_next, cur_next;
    logic [7:0]    mem [CAPACITY];
    logic [7:0]    rd_reg;
    logic [AW-1:0] raddr;
    logic          rd_en;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          wr_en;
    logic [PW-1:0] glen, tlen, cur_step;
    logic          zero_rd_reg, zero_rd_next;
    logic          rv_reg, rv_next;
    logic [7:0]    co_reg, co_next;
    logic [1:0]    st_reg, st_next;
    logic          needs_gap;
    logic [PW-1:0] avail, dcnt;

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[waddr] <= wdata;
        if (rd_en) rd_reg <= mem[raddr];
    end

    assign glen = gp_reg - gf_reg;
    assign tlen = PW'(CAPACITY) - glen;
    assign avail = tlen - cur_reg;
    assign dcnt = (PW'(req_reg.count) > avail) ? avail : PW'(req_reg.count);
    assign q_take = (state_reg == S_IDLE) && q_valid && !(rv_reg && !res_ready);
    assign needs_gap = (req_reg.func == FN_INSA || req_reg.func == FN_INS
                        || req_reg.func == FN_DEL
                        || (req_reg.func == FN_REPL && cur_reg >= tlen))
                       && !((req_reg.func != FN_DEL) && glen == '0);

    function automatic logic [AW-1:0] phys(input logic [PW-1:0] l,
                                           input logic [PW-1:0] gf,
                                           input logic [PW-1:0] gl);
        logic [PW-1:0] p;
        p = (l < gf) ? l : l + gl;
        return (p < PW'(CAPACITY)) ? p[AW-1:0] : '0;
    endfunction

    always_comb
    begin
        rd_en = 1'b0;
        raddr = '0;
        cur_step = cur_reg;
        case (state_reg)
            S_EXEC:
            begin
                if (needs_gap && cur_reg < gf_reg)
                begin
                    rd_en = 1'b1;
                    raddr = AW'(gf_reg - 1'b1);
                end
                else if (needs_gap && cur_reg > gf_reg)
                begin
                    rd_en = 1'b1;
                    raddr = gp_reg[AW-1:0];
                end
                else if (!needs_gap)
                begin
                    rd_en = 1'b1;
                    if (req_reg.func == FN_NEXT) cur_step = cur_reg + 1'b1;
                    if (req_reg.func == FN_PREV) cur_step = cur_reg - 1'b1;
                    raddr = phys(cur_step, gf_reg, glen);
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        wr_en = 1'b0;
        waddr = '0;
        wdata = rd_reg;
        case (state_reg)
            S_WR:
            begin
                wr_en = 1'b1;
                if (cur_reg < gf_reg) waddr = AW'(gp_reg - 1'b1);
                else waddr = gf_reg[AW-1:0];
            end
            S_EXEC:
            begin
                if (needs_gap && cur_reg == gf_reg && req_reg.func != FN_DEL)
                begin
                    wr_en = 1'b1;
                    waddr = gf_reg[AW-1:0];
                    wdata = req_reg.char_in;
                end
                else if (!needs_gap && req_reg.func == FN_REPL && cur_reg < tlen)
                begin
                    wr_en = 1'b1;
                    waddr = phys(cur_reg, gf_reg, glen);
                    wdata = req_reg.char_in;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_take) req_reg <= q_req;
    end

    always_comb
    begin
        state_next   = state_reg;
        gf_next      = gf_reg;
        gp_next      = gp_reg;
        cur_next     = cur_reg;
        rv_next      = rv_reg && !res_ready;
        co_next      = co_reg;
        st_next      = st_reg;
        zero_rd_next = zero_rd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_take)
                begin
                    st_next = ST_OK;
                    co_next = '0;
                    if (q_req.func == FN_SET)
                    begin
                        if (PW'(q_req.position) > tlen)
                        begin
                            cur_next = tlen;
                            st_next  = ST_OOR;
                        end
                        else cur_next = PW'(q_req.position);
                        rv_next = 1'b1;
                    end
                    else
                    begin
                        if (q_req.func == FN_DEL && PW'(q_req.count) > avail)
                            st_next = ST_OOR;
                        state_next = S_EXEC;
                    end
                end
            end
            S_WR:
            begin
                if (cur_reg < gf_reg)
                begin
                    gf_next = gf_reg - 1'b1;
                    gp_next = gp_reg - 1'b1;
                end
                else
                begin
                    gf_next = gf_reg + 1'b1;
                    gp_next = gp_reg + 1'b1;
                end
                state_next = S_EXEC;
            end
            S_DATA:
            begin
                co_next    = zero_rd_reg ? 8'd0 : rd_reg;
                rv_next    = 1'b1;
                state_next = S_IDLE;
            end
            S_EXEC:
            begin
                if (needs_gap && cur_reg != gf_reg)
                    state_next = S_WR;
                else if (needs_gap)
                begin
                    if (req_reg.func == FN_DEL)
                        gp_next = gp_reg + dcnt;
                    else
                    begin
                        gf_next = gf_reg + 1'b1;
                        if (req_reg.func == FN_INSA) cur_next = cur_reg + 1'b1;
                    end
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_IDLE;
                    rv_next    = 1'b1;
                    case (req_reg.func)
                        FN_READ:
                        begin
                            if (cur_reg < tlen)
                            begin
                                zero_rd_next = 1'b0;
                                state_next   = S_DATA;
                                rv_next      = 1'b0;
                            end
                            else st_next = ST_OOR;
                        end
                        FN_NEXT:
                        begin
                            if (cur_reg < tlen)
                            begin
                                cur_next     = cur_step;
                                zero_rd_next = !(cur_step < tlen);
                                state_next   = S_DATA;
                                rv_next      = 1'b0;
                            end
                            else st_next = ST_OOR;
                        end
                        FN_PREV:
                        begin
                            if (cur_reg != '0)
                            begin
                                cur_next     = cur_step;
                                zero_rd_next = 1'b0;
                                state_next   = S_DATA;
                                rv_next      = 1'b0;
                            end
                            else st_next = ST_OOR;
                        end
                        FN_INSA, FN_INS: st_next = ST_FULL;
                        FN_REPL:
                        begin
                            // overwrite inside the text is fine; only an append can be full
                            if (cur_reg >= tlen) st_next = ST_FULL;
                        end
                        default: ;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            gf_reg      <= '0;
            gp_reg      <= PW'(CAPACITY);
            cur_reg     <= '0;
            rv_reg      <= 1'b0;
            co_reg      <= '0;
            st_reg      <= ST_OK;
            zero_rd_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            gf_reg      <= gf_next;
            gp_reg      <= gp_next;
            cur_reg     <= cur_next;
            rv_reg      <= rv_next;
            co_reg      <= co_next;
            st_reg      <= st_next;
            zero_rd_reg <= zero_rd_next;
        end
    end

    assign res_valid   = rv_reg;
    assign char_out    = co_reg;
    assign text_length = 11'(tlen);
    assign cursor_pos  = 11'(cur_reg);
    assign free_space  = 11'(glen);
    assign status      = st_reg;

    a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
        gf_reg <= gp_reg)
        else $error("gap bounds crossed");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= tlen)
        else $error("cursor past text");

    // the copy step reads in S_EXEC, so S_WR always follows with one read done
    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR |-> $past(state_reg) == S_EXEC)
        else $error("copy write without read");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && !res_ready |=> rv_reg
            && $stable({co_reg, st_reg, cur_reg, gf_reg, gp_reg}))
        else $error("result changed while waiting");
endmodule
